/* rtl/usph_pkg.sv */
// shared constants, types and tables of the uv sphere tessellator
package usph_pkg;

  localparam int MAX_SEGMENTS_DEF = 255;

  // long division: dividend width, quotient bits per stage, stage count
  localparam int DIV_NUM_W     = 40;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = DIV_NUM_W / DIV_PER_STAGE;

  // cordic: micro-rotations, rotations per stage, stage count
  localparam int CORDIC_STEPS     = 20;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int CORDIC_W         = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;

  localparam int POS_STAGES = 4;
  localparam int POS_W      = 17;
  localparam int TEX_W      = 17;
  localparam int IDX_W      = 16;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_RING   = 2'd1,
    CFG_COLUMN = 2'd2
  } cfg_idx_t;

  // per-item bookkeeping that rides along the pipeline
  typedef struct packed {
    logic [IDX_W-1:0] top_next;
    logic [IDX_W-1:0] top_here;
    logic [IDX_W-1:0] bot_here;
    logic [IDX_W-1:0] bot_next;
    logic             upper_ok;
    logic             lower_ok;
    logic             outside;
  } side_t;

  typedef struct packed {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
  } tex_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
    logic signed [CORDIC_W-1:0] a;
    unique case (i)
      0:  a = 33'sd536870912;
      1:  a = 33'sd316933406;
      2:  a = 33'sd167458907;
      3:  a = 33'sd85004756;
      4:  a = 33'sd42667331;
      5:  a = 33'sd21354465;
      6:  a = 33'sd10679838;
      7:  a = 33'sd5340245;
      8:  a = 33'sd2670163;
      9:  a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/usph_div.sv */
// pipelined restoring divider by an 8 bit divisor, four quotient bits per stage
module usph_div (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [usph_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [7:0]                     den_i,
  output logic [usph_pkg::DIV_NUM_W-1:0] quo_o
);
  import usph_pkg::*;

  // remainder and a shift word: dividend bits leave at the top, quotient enters below
  function automatic logic [8+DIV_NUM_W-1:0] div_step(input logic [7:0] rem_in,
                                                      input logic [DIV_NUM_W-1:0] sh_in,
                                                      input logic [7:0] den);
    logic [7:0]           rem;
    logic [DIV_NUM_W-1:0] sh;
    logic [8:0]           r2;
    rem = rem_in;
    sh  = sh_in;
    for (int j = 0; j < DIV_PER_STAGE; j++) begin
      r2 = {rem, sh[DIV_NUM_W-1]};
      sh = {sh[DIV_NUM_W-2:0], 1'b0};
      if (r2 >= {1'b0, den}) begin
        rem   = 8'(r2 - {1'b0, den});
        sh[0] = 1'b1;
      end else begin
        rem = r2[7:0];
      end
    end
    return {rem, sh};
  endfunction

  logic [7:0]           rem_r [DIV_STAGES];
  logic [DIV_NUM_W-1:0] sh_r  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [7:0]           rem_in;
    logic [DIV_NUM_W-1:0] sh_in;
    logic [8+DIV_NUM_W-1:0] step_nxt;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign sh_in  = num_i;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign sh_in  = sh_r[s-1];
    end
    assign step_nxt = div_step(rem_in, sh_in, den_i);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= step_nxt[8+DIV_NUM_W-1:DIV_NUM_W];
        sh_r[s]  <= step_nxt[DIV_NUM_W-1:0];
      end
    end
  end

  assign quo_o = sh_r[DIV_STAGES-1];

endmodule

/* rtl/usph_cordic.sv */
// pipelined rotation cordic, cosine and sine in q2.30 of a 32 bit turn angle
module usph_cordic (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [31:0]                          angle_i,
  output logic signed [usph_pkg::CORDIC_W-1:0] cos_o,
  output logic signed [usph_pkg::CORDIC_W-1:0] sin_o
);
  import usph_pkg::*;

  localparam int VEC_W = 3 * CORDIC_W;

  function automatic logic [VEC_W-1:0] rot(input logic signed [CORDIC_W-1:0] x_in,
                                           input logic signed [CORDIC_W-1:0] y_in,
                                           input logic signed [CORDIC_W-1:0] z_in,
                                           input int i);
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    x  = x_in;
    y  = y_in;
    z  = z_in;
    dx = y >>> i;
    dy = x >>> i;
    if (z >= 0) begin
      x = x - dx;
      y = y + dy;
      z = z - atan_turn(i);
    end else begin
      x = x + dx;
      y = y - dy;
      z = z + atan_turn(i);
    end
    return {x, y, z};
  endfunction

  logic signed [CORDIC_W-1:0] x_r [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] y_r [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] z_r [CORDIC_STAGES];
  logic [1:0]                 q_r [CORDIC_STAGES];

  // nearest quadrant and residual within an eighth of a turn
  logic [31:0] ang_bias;
  logic [1:0]  quad0;
  logic [31:0] resid;
  assign ang_bias = angle_i + 32'h2000_0000;
  assign quad0    = ang_bias[31:30];
  assign resid    = angle_i - {quad0, 30'b0};

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [CORDIC_W-1:0] x_in;
    logic signed [CORDIC_W-1:0] y_in;
    logic signed [CORDIC_W-1:0] z_in;
    logic [1:0]                 q_in;
    logic [VEC_W-1:0]           v [CORDIC_PER_STAGE+1];
    if (s == 0) begin : g_first
      assign x_in = CORDIC_START;
      assign y_in = '0;
      assign z_in = CORDIC_W'(signed'(resid));
      assign q_in = quad0;
    end else begin : g_rest
      assign x_in = x_r[s-1];
      assign y_in = y_r[s-1];
      assign z_in = z_r[s-1];
      assign q_in = q_r[s-1];
    end
    assign v[0] = {x_in, y_in, z_in};
    for (genvar j = 0; j < CORDIC_PER_STAGE; j++) begin : g_rot
      assign v[j+1] = rot(v[j][VEC_W-1:2*CORDIC_W], v[j][2*CORDIC_W-1:CORDIC_W],
                          v[j][CORDIC_W-1:0], s * CORDIC_PER_STAGE + j);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[s] <= v[CORDIC_PER_STAGE][VEC_W-1:2*CORDIC_W];
        y_r[s] <= v[CORDIC_PER_STAGE][2*CORDIC_W-1:CORDIC_W];
        z_r[s] <= v[CORDIC_PER_STAGE][CORDIC_W-1:0];
        q_r[s] <= q_in;
      end
    end
  end

  // turn back by the quadrant
  always_comb begin
    unique case (q_r[CORDIC_STAGES-1])
      2'd0: begin
        cos_o = x_r[CORDIC_STAGES-1];
        sin_o = y_r[CORDIC_STAGES-1];
      end
      2'd1: begin
        cos_o = -y_r[CORDIC_STAGES-1];
        sin_o = x_r[CORDIC_STAGES-1];
      end
      2'd2: begin
        cos_o = -x_r[CORDIC_STAGES-1];
        sin_o = -y_r[CORDIC_STAGES-1];
      end
      default: begin
        cos_o = y_r[CORDIC_STAGES-1];
        sin_o = -x_r[CORDIC_STAGES-1];
      end
    endcase
  end

endmodule

/* rtl/usph_pos.sv */
// position products, rounding and saturation, four register stages
module usph_pos (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [usph_pkg::CORDIC_W-1:0] cp_i,
  input  logic signed [usph_pkg::CORDIC_W-1:0] sp_i,
  input  logic signed [usph_pkg::CORDIC_W-1:0] ct_i,
  input  logic signed [usph_pkg::CORDIC_W-1:0] st_i,
  input  logic [15:0]                          radius_i,
  output logic signed [usph_pkg::POS_W-1:0]    pos_x_o,
  output logic signed [usph_pkg::POS_W-1:0]    pos_y_o,
  output logic signed [usph_pkg::POS_W-1:0]    pos_z_o
);
  import usph_pkg::*;

  localparam int PW = 2 * CORDIC_W;

  function automatic logic signed [PW-1:0] rnd30(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + PW'(64'sd536870912);
    return t >>> 30;
  endfunction

  function automatic logic signed [POS_W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > PW'(64'sd65535)) r = 17'sd65535;
    else if (v < -PW'(64'sd65535)) r = -17'sd65535;
    else r = POS_W'(v);
    return r;
  endfunction

  logic signed [16:0] rad_s;
  assign rad_s = signed'({1'b0, radius_i});

  logic signed [PW-1:0]       pcs_r, pss_r, pyc_r;
  logic signed [PW-1:0]       pcs_nxt, pss_nxt, pyc_nxt;
  logic signed [CORDIC_W-1:0] tx_r, tz_r;
  logic signed [POS_W-1:0]    y2_r, y3_r, y4_r;
  logic signed [PW-1:0]       mx_r, mz_r, mx_nxt, mz_nxt;
  logic signed [POS_W-1:0]    x4_r, z4_r;

  assign pcs_nxt = cp_i * st_i;
  assign pss_nxt = sp_i * st_i;
  assign pyc_nxt = PW'(rad_s) * PW'(ct_i);
  assign mx_nxt  = PW'(rad_s) * PW'(tx_r);
  assign mz_nxt  = PW'(rad_s) * PW'(tz_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pcs_r <= pcs_nxt;
      pss_r <= pss_nxt;
      pyc_r <= pyc_nxt;
      tx_r  <= CORDIC_W'(rnd30(pcs_r));
      tz_r  <= CORDIC_W'(rnd30(pss_r));
      y2_r  <= sat(rnd30(pyc_r));
      mx_r  <= mx_nxt;
      mz_r  <= mz_nxt;
      y3_r  <= y2_r;
      x4_r  <= sat(rnd30(-mx_r));
      z4_r  <= sat(rnd30(mz_r));
      y4_r  <= y3_r;
    end
  end

  assign pos_x_o = x4_r;
  assign pos_y_o = y4_r;
  assign pos_z_o = z4_r;

endmodule

/* rtl/uv_sphere_tessellator.sv */
// top level of the uv sphere tessellator: config registers, pipeline, output
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    ring, column
//   out_     output     out_valid / out_ready  position, texture, corners, flags
//   cfg_     input      cfg_valid / cfg_ready  register index, write data
//
// one request enters per cycle while the pipeline advances; a result passes through
// 10 divider, 10 cordic and 4 product stages on its way to the outputs
// the whole pipeline advances together whenever the output register is empty
// or taken, so a stall freezes every stage and nothing is lost or repeated
// reset clears the valid bits and loads the register reset values; cfg_ready is
// always high
module uv_sphere_tessellator #(
  parameter int MAX_SEGMENTS = usph_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_ring,
  input  logic [7:0]                          in_column,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [usph_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [usph_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [usph_pkg::POS_W-1:0]   out_pos_z,
  output logic [usph_pkg::TEX_W-1:0]          out_tex_u,
  output logic [usph_pkg::TEX_W-1:0]          out_tex_v,
  output logic [usph_pkg::IDX_W-1:0]          out_corner_top_next,
  output logic [usph_pkg::IDX_W-1:0]          out_corner_top_here,
  output logic [usph_pkg::IDX_W-1:0]          out_corner_bottom_here,
  output logic [usph_pkg::IDX_W-1:0]          out_corner_bottom_next,
  output logic                                out_upper_triangle_valid,
  output logic                                out_lower_triangle_valid,
  output logic                                out_outside_grid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data
);
  import usph_pkg::*;

  localparam int LAT     = DIV_STAGES + CORDIC_STAGES + POS_STAGES;
  localparam int TEX_LAT = CORDIC_STAGES + POS_STAGES;
  // segment counts above the cap are used as the cap
  localparam logic [7:0] SEG_CAP = (MAX_SEGMENTS > 255) ? 8'd255 : 8'(MAX_SEGMENTS);

  // configuration registers
  logic [15:0] radius_r;
  logic [7:0]  ring_seg_r;
  logic [7:0]  col_seg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 16'd256;
      ring_seg_r <= 8'd16;
      col_seg_r  <= 8'd16;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RADIUS: radius_r   <= cfg_data;
        CFG_RING:   ring_seg_r <= cfg_data[7:0];
        CFG_COLUMN: col_seg_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective segment counts, clamped to the legal range
  logic [7:0] h_eff, w_eff;
  always_comb begin
    h_eff = (ring_seg_r < 8'd2) ? 8'd2 : ring_seg_r;
    if (h_eff > SEG_CAP) h_eff = SEG_CAP;
    w_eff = (col_seg_r < 8'd3) ? 8'd3 : col_seg_r;
    if (w_eff > SEG_CAP) w_eff = SEG_CAP;
  end

  // whole pipeline moves as one
  logic adv;
  logic vld_r [LAT];
  assign adv      = !vld_r[LAT-1] || out_ready;
  assign in_ready = adv;

  // quad bookkeeping worked out at entry; rows hold w+1 vertices
  side_t       side_in;
  logic [16:0] top_idx, bot_idx;
  logic        in_quad;
  assign top_idx = 17'(in_ring) * (17'(w_eff) + 17'd1) + 17'(in_column);
  assign bot_idx = top_idx + 17'(w_eff) + 17'd1;
  assign in_quad = (in_ring < h_eff) && (in_column < w_eff);

  always_comb begin
    side_in = '0;
    side_in.outside = (in_ring > h_eff) || (in_column > w_eff);
    if (in_quad) begin
      side_in.top_next = IDX_W'(top_idx + 17'd1);
      side_in.top_here = IDX_W'(top_idx);
      side_in.bot_here = IDX_W'(bot_idx);
      side_in.bot_next = IDX_W'(bot_idx + 17'd1);
      side_in.upper_ok = (in_ring != 8'd0);
      side_in.lower_ok = (in_ring != 8'(h_eff - 8'd1));
    end
  end

  side_t side_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int k = 1; k < LAT; k++) side_r[k] <= side_r[k-1];
    end
  end

  // dividends: index times 2^k plus half the divisor, rounding the quotient
  logic [DIV_NUM_W-1:0] phi_num, theta_num, u_num, v_num;
  logic [DIV_NUM_W-1:0] phi_q, theta_q, u_q, v_q;
  assign phi_num   = {in_column, 32'b0} + DIV_NUM_W'(w_eff >> 1);
  assign theta_num = DIV_NUM_W'({in_ring, 31'b0}) + DIV_NUM_W'(h_eff >> 1);
  assign u_num     = DIV_NUM_W'({in_column, 16'b0}) + DIV_NUM_W'(w_eff >> 1);
  assign v_num     = DIV_NUM_W'({in_ring, 16'b0}) + DIV_NUM_W'(h_eff >> 1);

  usph_div u_div_phi   (.clk(clk), .adv(adv), .num_i(phi_num),   .den_i(w_eff), .quo_o(phi_q));
  usph_div u_div_theta (.clk(clk), .adv(adv), .num_i(theta_num), .den_i(h_eff), .quo_o(theta_q));
  usph_div u_div_u     (.clk(clk), .adv(adv), .num_i(u_num),     .den_i(w_eff), .quo_o(u_q));
  usph_div u_div_v     (.clk(clk), .adv(adv), .num_i(v_num),     .den_i(h_eff), .quo_o(v_q));

  // texture coordinates wait for the position math
  tex_t tex_r [TEX_LAT];
  always_ff @(posedge clk) begin
    if (adv) begin
      tex_r[0] <= '{u: u_q[TEX_W-1:0], v: v_q[TEX_W-1:0]};
      for (int k = 1; k < TEX_LAT; k++) tex_r[k] <= tex_r[k-1];
    end
  end

  // longitude angle wraps a full turn back to zero
  logic signed [CORDIC_W-1:0] cp, sp, ct, st;
  usph_cordic u_cordic_phi (
    .clk(clk), .adv(adv), .angle_i(phi_q[31:0]), .cos_o(cp), .sin_o(sp)
  );
  usph_cordic u_cordic_theta (
    .clk(clk), .adv(adv), .angle_i(theta_q[31:0]), .cos_o(ct), .sin_o(st)
  );

  logic signed [POS_W-1:0] px, py, pz;
  usph_pos u_pos (
    .clk(clk), .adv(adv), .cp_i(cp), .sp_i(sp), .ct_i(ct), .st_i(st),
    .radius_i(radius_r), .pos_x_o(px), .pos_y_o(py), .pos_z_o(pz)
  );

  // points past the grid report zeros and the flag
  side_t last;
  logic  live;
  assign last = side_r[LAT-1];
  assign live = !last.outside;

  assign out_valid                = vld_r[LAT-1];
  assign out_pos_x                = live ? px : '0;
  assign out_pos_y                = live ? py : '0;
  assign out_pos_z                = live ? pz : '0;
  assign out_tex_u                = live ? tex_r[TEX_LAT-1].u : '0;
  assign out_tex_v                = live ? tex_r[TEX_LAT-1].v : '0;
  assign out_corner_top_next      = last.top_next;
  assign out_corner_top_here      = last.top_here;
  assign out_corner_bottom_here   = last.bot_here;
  assign out_corner_bottom_next   = last.bot_next;
  assign out_upper_triangle_valid = last.upper_ok;
  assign out_lower_triangle_valid = last.lower_ok;
  assign out_outside_grid         = last.outside;

endmodule

/* test/sphere_checker.sv */
// checker of the uv sphere tessellator: predicts every point and compares results
module sphere_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_ring,
  input  logic [7:0]        in_column,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [16:0]       out_pos_x,
  input  logic [16:0]       out_pos_y,
  input  logic [16:0]       out_pos_z,
  input  logic [16:0]       out_tex_u,
  input  logic [16:0]       out_tex_v,
  input  logic [15:0]       out_corner_top_next,
  input  logic [15:0]       out_corner_top_here,
  input  logic [15:0]       out_corner_bottom_here,
  input  logic [15:0]       out_corner_bottom_next,
  input  logic              out_upper_triangle_valid,
  input  logic              out_lower_triangle_valid,
  input  logic              out_outside_grid,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                fail_count,
  output int                pending_points,
  output int                points_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import usph_pkg::*;

  typedef struct packed {
    logic [16:0] px, py, pz, u, v;
    logic [15:0] tn, th, bh, bn;
    logic up, lo, outside;
  } vertex_t;

  vertex_t vertex_q[$];
  logic [15:0] radius;
  logic [7:0]  rings, cols;

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 65535) return 65535;
    if (v < -65535) return -65535;
    return v;
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] q, r;
    longint z, x, y, dx, dy;
    q = ((ang + 32'h2000_0000) >> 30) & 3;
    r = ang - q * 32'h4000_0000;
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      dx = fl_shift(y, i);
      dy = fl_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_vertex(input logic [7:0] ring, input logic [7:0] col,
                                output vertex_t e);
    longint unsigned h, w, top, bot;
    longint cp, sp, ct, st, t, rr;
    logic [31:0] phi, theta;
    h = rings < 2 ? 2 : rings;
    w = cols < 3 ? 3 : cols;
    rr = radius;
    e = '0;
    if (ring > h || col > w) begin
      e.outside = 1'b1;
      return;
    end
    phi = 32'((((64'(col)) << 32) + w / 2) / w);
    theta = 32'((((64'(ring)) << 31) + h / 2) / h);
    rotate(phi, cp, sp);
    rotate(theta, ct, st);
    t = rnd_shift(cp * st, 30);
    e.px = 17'(sat(rnd_shift(-(rr * t), 30)));
    e.py = 17'(sat(rnd_shift(rr * ct, 30)));
    t = rnd_shift(sp * st, 30);
    e.pz = 17'(sat(rnd_shift(rr * t, 30)));
    e.u = 17'((col * 65536 + w / 2) / w);
    e.v = 17'((ring * 65536 + h / 2) / h);
    if (ring < h && col < w) begin
      top = ring * (w + 1) + col;
      bot = (ring + 1) * (w + 1) + col;
      e.tn = 16'(top + 1);
      e.th = 16'(top);
      e.bh = 16'(bot);
      e.bn = 16'(bot + 1);
      e.up = ring != 0;
      e.lo = ring != h - 1;
    end
  endtask

  assign pending_points = vertex_q.size();

  always @(posedge clk) begin
    vertex_t e, a;
    if (!rst_n) begin
      radius <= 16'd256;
      rings <= 8'd16;
      cols <= 8'd16;
      fail_count <= 0;
      points_checked <= 0;
      vertex_q.delete();
    end else begin
      // nonblocking writes: a prediction uses the settings from before this edge's config write
      if (out_valid && out_ready) begin
        a = {out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v,
             out_corner_top_next, out_corner_top_here, out_corner_bottom_here,
             out_corner_bottom_next, out_upper_triangle_valid,
             out_lower_triangle_valid, out_outside_grid};
        points_checked <= points_checked + 1;
        if (vertex_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("result with nothing expected: %p", a);
        end else begin
          e = vertex_q.pop_front();
          if (e !== a) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch\n  expected %p\n  actual   %p", e, a);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_vertex(in_ring, in_column, e);
        vertex_q.insert(vertex_q.size(), e);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RADIUS: radius <= cfg_data;
          CFG_RING:   rings <= cfg_data[7:0];
          CFG_COLUMN: cols <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* test/testbench.sv */
// top of the uv sphere tessellator testbench: stimulus, settings and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import usph_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [7:0] in_ring, in_column;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic signed [16:0] out_pos_x, out_pos_y, out_pos_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic [15:0] out_corner_top_next, out_corner_top_here;
  logic [15:0] out_corner_bottom_here, out_corner_bottom_next;
  logic out_upper_triangle_valid, out_lower_triangle_valid, out_outside_grid;
  int fail_count, pending_points, points_checked;
  int requests_sent, settings_used;

  uv_sphere_tessellator DUT (.*);

  sphere_checker checker_i (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: far beyond the slowest correct run (about 2000 requests with
  // random gaps and random stalls plus pipeline latency)
  initial begin
    #(12 * 300000);
    $display("timeout");
    $display("testbench: FAIL");
    $finish;
  end

  // receiver: random stall drawn per result, some results taken without a stall
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // one request with a random gap before it; the gap is skipped in calm phases
  // valid stays high after acceptance until the next gap or a drain
  task automatic send_point(input logic [7:0] ring, input logic [7:0] col, input bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ring <= ring;
    in_column <= col;
    @(posedge clk iff in_ready);
    requests_sent++;
  endtask

  // let the pipeline drain fully, then add a margin of idle clocks
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk iff pending_points == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk iff cfg_ready);
  endtask

  task automatic apply_setting(input logic [15:0] rad, input logic [7:0] h,
                               input logic [7:0] w);
    drain_pipeline();
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_RING, {8'h00, h});
    write_reg(CFG_COLUMN, {8'h00, w});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // mostly points on or near the grid, some anywhere
  task automatic random_points(input int n, input logic [7:0] h, input logic [7:0] w);
    logic [7:0] r, c;
    bit calm;
    for (int i = 0; i < n; i++) begin
      calm = (i / 40) % 4 == 3;
      if ($urandom_range(0, 9) < 8) begin
        r = 8'($urandom_range(0, (h < 2 ? 2 : h)));
        c = 8'($urandom_range(0, (w < 3 ? 3 : w)));
      end else begin
        r = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
      end
      send_point(r, c, calm);
    end
  endtask

  initial begin
    logic [15:0] rad;
    logic [7:0] h, w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ring = '0;
    in_column = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RADIUS;
    cfg_data = '0;
    requests_sent = 0;
    settings_used = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at reset settings: poles, last row and column, off-grid, extremes
    send_point(0, 0, 1);
    send_point(0, 15, 1);
    send_point(15, 0, 0);
    send_point(15, 15, 0);
    send_point(16, 16, 1);
    send_point(16, 0, 0);
    send_point(8, 4, 0);
    send_point(17, 0, 1);
    send_point(0, 17, 1);
    send_point(255, 255, 0);
    send_point(8'hAA, 8'h55, 0);
    send_point(8'h55, 8'hAA, 0);

    // sender holds until the pipeline is empty
    in_valid <= 1'b0;
    @(posedge clk iff pending_points == 0);

    // segment counts below the minimum are raised, top radius saturates
    apply_setting(16'hFFFF, 8'd0, 8'd0);
    send_point(2, 3, 1);
    send_point(1, 1, 0);
    send_point(0, 2, 0);
    send_point(3, 0, 0);
    apply_setting(16'd0, 8'd255, 8'd255);
    send_point(255, 255, 1);
    send_point(254, 254, 0);
    send_point(128, 64, 0);
    send_point(0, 255, 0);
    apply_setting(16'd1, 8'd2, 8'd3);
    send_point(1, 2, 0);
    send_point(2, 3, 0);

    // random phases across many settings, extremes included
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin rad = 16'hFFFF; h = 8'd255; w = 8'd255; end
        1: begin rad = 16'd0; h = 8'd1; w = 8'd2; end
        2: begin rad = 16'd256; h = 8'd16; w = 8'd16; end
        default: begin
          rad = 16'($urandom_range(0, 65535));
          h = 8'($urandom_range(0, 255));
          w = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1)) begin
            h = 8'($urandom_range(2, 20));
            w = 8'($urandom_range(3, 20));
          end
        end
      endcase
      apply_setting(rad, h, w);
      random_points(160, h, w);
    end

    drain_pipeline();
    $display("covered %0d requests and %0d results over %0d register settings",
             requests_sent, points_checked, settings_used);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/usph_pkg.sv
rtl/usph_div.sv
rtl/usph_cordic.sv
rtl/usph_pos.sv
rtl/uv_sphere_tessellator.sv
test/sphere_checker.sv
test/testbench.sv
